### hdl/pgar_pkg.sv
// Package: transaction types and code constants for the printer gate array registers.
package pgar_pkg;

    typedef logic [2:0] t_action;
    typedef logic [2:0] t_offset;

    localparam t_action ACT_BUS_WRITE  = 3'd0;
    localparam t_action ACT_BUS_READ   = 3'd1;
    localparam t_action ACT_STROBE     = 3'd2;
    localparam t_action ACT_HOST_INIT  = 3'd3;
    localparam t_action ACT_RESET_LINE = 3'd4;

    localparam t_offset WR_SHIFT_HI    = 3'd0;
    localparam t_offset WR_SHIFT_MID   = 3'd1;
    localparam t_offset WR_SHIFT_LO    = 3'd2;
    localparam t_offset WR_CONTROL     = 3'd3;
    localparam t_offset WR_HEAD_LO     = 3'd4;
    localparam t_offset WR_HEAD_HI     = 3'd5;
    localparam t_offset WR_FEED        = 3'd6;
    localparam t_offset WR_CARRIAGE    = 3'd7;

    localparam t_offset RD_PORT_LATCH  = 3'd0;
    localparam t_offset RD_STATUS      = 3'd1;
    localparam t_offset RD_PORT_LIVE   = 3'd2;
    localparam t_offset RD_SHIFT_OUT   = 3'd3;

    typedef struct packed {
        t_action    action;
        t_offset    offset;
        logic [7:0] write_data;
        logic       line_level;
        logic [7:0] port_data;
        logic       home_sensor;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [15:0] head_drive;
        logic [3:0]  feed_phase;
        logic [3:0]  carriage_phase;
        logic        busy_line;
        logic        paper_error_line;
        logic        paper_lamp;
        logic        reset_pulse;
    } t_out_item;

endpackage

### hdl/pgar_regs.sv
// Register file and event decode: updates state for one transaction and forms its result.
module pgar_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  pgar_pkg::t_in_item  i_item,
    output pgar_pkg::t_out_item o_result
);

    typedef struct packed {
        logic [23:0] shift_bits;
        logic        busy_leading;
        logic        busy_software;
        logic        nlq_lamp;
        logic        condensed_lamp;
        logic [8:0]  head_pattern;
        logic [3:0]  feed_bits;
        logic [3:0]  carriage_bits;
        logic [7:0]  port_latch;
        logic        latched;
        logic        busy;
        logic        paper_error;
        logic        strobe_prev;
        logic        init_prev;
    } t_state;

    localparam t_state STATE_RESET = '{
        shift_bits:     24'd0,
        busy_leading:   1'b0,
        busy_software:  1'b1,
        nlq_lamp:       1'b1,
        condensed_lamp: 1'b1,
        head_pattern:   9'd0,
        feed_bits:      4'd0,
        carriage_bits:  4'hf,
        port_latch:     8'd0,
        latched:        1'b0,
        busy:           1'b0,
        paper_error:    1'b0,
        strobe_prev:    1'b1,
        init_prev:      1'b1
    };

    function automatic t_state internal_reset(input t_state s);
        t_state t;
        t                = s;
        t.head_pattern   = 9'd0;
        t.feed_bits      = 4'd0;
        t.carriage_bits  = 4'hf;
        t.busy_software  = 1'b1;
        t.nlq_lamp       = 1'b1;
        t.condensed_lamp = 1'b1;
        t.busy           = 1'b0;
        t.paper_error    = 1'b0;
        return t;
    endfunction

    t_state     r_state;
    t_state     n_state;
    logic [7:0] rd;
    logic       pulse;

    always_comb begin
        n_state = r_state;
        rd      = 8'd0;
        pulse   = 1'b0;
        case (i_item.action)
            pgar_pkg::ACT_BUS_WRITE: begin
                unique case (i_item.offset)
                    pgar_pkg::WR_SHIFT_HI:  n_state.shift_bits[23:16] = i_item.write_data;
                    pgar_pkg::WR_SHIFT_MID: n_state.shift_bits[15:8]  = i_item.write_data;
                    pgar_pkg::WR_SHIFT_LO:  n_state.shift_bits[7:0]   = i_item.write_data;
                    pgar_pkg::WR_CONTROL: begin
                        n_state.busy_leading   = i_item.write_data[7];
                        n_state.busy_software  = i_item.write_data[6];
                        n_state.nlq_lamp       = i_item.write_data[4];
                        n_state.condensed_lamp = i_item.write_data[3];
                        n_state.paper_error    = i_item.write_data[2];
                    end
                    pgar_pkg::WR_HEAD_LO:  n_state.head_pattern[7:0] = i_item.write_data;
                    pgar_pkg::WR_HEAD_HI:  n_state.head_pattern[8]   = i_item.write_data[7];
                    pgar_pkg::WR_FEED:     n_state.feed_bits         = i_item.write_data[7:4];
                    pgar_pkg::WR_CARRIAGE: n_state.carriage_bits     = i_item.write_data[3:0];
                    default: ;
                endcase
            end
            pgar_pkg::ACT_BUS_READ: begin
                unique case (i_item.offset)
                    pgar_pkg::RD_PORT_LATCH: begin
                        n_state.latched = 1'b0;
                        n_state.busy    = 1'b0;
                        rd              = r_state.port_latch;
                    end
                    pgar_pkg::RD_STATUS:    rd = {r_state.latched, i_item.home_sensor, 6'd0};
                    pgar_pkg::RD_PORT_LIVE: rd = i_item.port_data;
                    pgar_pkg::RD_SHIFT_OUT: begin
                        rd                 = {r_state.shift_bits[23], 7'd0};
                        n_state.shift_bits = {r_state.shift_bits[22:0], 1'b0};
                    end
                    default: ;
                endcase
            end
            pgar_pkg::ACT_STROBE: begin
                if (r_state.strobe_prev && !i_item.line_level && !r_state.busy) begin
                    n_state.port_latch = i_item.port_data;
                    n_state.latched    = 1'b1;
                    n_state.busy       = 1'b1;
                end
                n_state.strobe_prev = i_item.line_level;
            end
            pgar_pkg::ACT_HOST_INIT: begin
                if (r_state.init_prev && !i_item.line_level) begin
                    n_state = internal_reset(r_state);
                end
                n_state.init_prev = i_item.line_level;
            end
            pgar_pkg::ACT_RESET_LINE: begin
                if (!i_item.line_level) begin
                    n_state = internal_reset(r_state);
                    pulse   = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        o_result.read_data        = rd;
        o_result.head_drive       = {7'h7f, ~n_state.head_pattern};
        o_result.feed_phase       = n_state.feed_bits;
        o_result.carriage_phase   = n_state.carriage_bits;
        o_result.busy_line        = n_state.busy;
        o_result.paper_error_line = n_state.paper_error;
        o_result.paper_lamp       = ~n_state.paper_error;
        o_result.reset_pulse      = pulse;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (i_en) begin
            r_state <= n_state;
        end
    end

endmodule

### hdl/printer_gate_array_registers_core.sv
// Top level: input register, register file update and result register with handshakes.
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+------------------------------
//  input   | i_in_valid  | o_in_ready  | i_in_item  (pgar_pkg::t_in_item)
//  output  | o_out_valid | i_out_ready | o_out_item (pgar_pkg::t_out_item)
//
// One transaction per cycle while the output is ready; output valid is registered.
// The register update runs between the input register and the result register.
// A stalled output holds the result; the input register fills, then o_in_ready drops.
// Synchronous active-low reset restores the register file and empties both stages.
module printer_gate_array_registers_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  pgar_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pgar_pkg::t_out_item o_out_item
);

    logic                r_in_valid;
    pgar_pkg::t_in_item  r_in_item;
    logic                r_out_valid;
    pgar_pkg::t_out_item r_out_item;
    pgar_pkg::t_out_item result;
    logic                advance;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    pgar_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_item   (r_in_item),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
        if (advance) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_out_valid && !i_out_ready))
        else $error("input stalled without a full pipeline");

    a_lamp_inverse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.paper_lamp != o_out_item.paper_error_line))
        else $error("paper lamp not inverse of paper error");

    a_pulse_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.reset_pulse) |->
            (o_out_item.head_drive == 16'hffff && o_out_item.carriage_phase == 4'hf &&
             o_out_item.feed_phase == 4'h0 && !o_out_item.busy_line &&
             o_out_item.read_data == 8'h00))
        else $error("reset pulse without reset values");

    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");
`endif

endmodule
